### hdl/awbs_pkg.sv
// ----------------------------------------------------------------------------
// awbs_pkg
// Shared types and constants of the affine warp bilinear sampler.
// ----------------------------------------------------------------------------
package awbs_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int PIXEL_BITS = 16;
  localparam int ADDR_W     = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [2:0] REG_A0 = 3'd0;
  localparam logic [2:0] REG_A1 = 3'd1;
  localparam logic [2:0] REG_A2 = 3'd2;
  localparam logic [2:0] REG_A3 = 3'd3;
  localparam logic [2:0] REG_TX = 3'd4;
  localparam logic [2:0] REG_TY = 3'd5;
  localparam logic [2:0] REG_W  = 3'd6;
  localparam logic [2:0] REG_H  = 3'd7;

  typedef struct packed {
    logic                  cmd;
    logic [7:0]            col;
    logic [7:0]            row;
    logic [PIXEL_BITS-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  singular;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FETCH,
    ST_HOLD
  } state_t;

endpackage

### hdl/affine_warp_bilinear_sampler_unit.sv
// ----------------------------------------------------------------------------
// affine_warp_bilinear_sampler_unit
// Frame store with affine back-mapping and bilinear blend of four neighbors.
// ----------------------------------------------------------------------------
//  channel | signals                       | role
//  in      | in_valid in_stall in_data     | load / sample words
//  out     | out_valid out_stall out_data  | one word per sample
//  cfg     | cfg_valid cfg_ready cfg_index | register writes, always ready
//          | cfg_data                      |
//
//  A load goes straight into the frame store. A sample runs on the shared
//  multiplier (det and two numerators), then in the two restoring divider
//  lanes, then through the four frame-store reads and weighted sum, and then
//  hands off the result. A singular matrix skips the divide steps and fetch.
//  The result register lets a load or a new sample enter while a word waits.
//  Reset is synchronous and stalls the input; the frame store is not cleared.
//  A stalled output only holds a finished sample in the hold state.
module affine_warp_bilinear_sampler_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  awbs_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output awbs_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [25:0]          cfg_data
);

  localparam int DW = 72;

  // configuration
  logic [25:0] a0, a1, a2, a3, tx, ty;
  logic [8:0]  w_cfg, h_cfg;

  awbs_pkg::state_t state, state_next;
  logic [4:0]  cnt;
  logic        cnt_clr;

  logic [7:0]  col_r, row_r;

  // frame store
  logic [awbs_pkg::PIXEL_BITS-1:0] mem [0:(1 << awbs_pkg::ADDR_W)-1];
  logic [awbs_pkg::ADDR_W-1:0]     raddr;
  logic [awbs_pkg::PIXEL_BITS-1:0] rdata;
  logic                            mem_we;

  // multiplier sequencer
  logic signed [26:0] mop_a, mop_b, dxs, dys;
  logic signed [53:0] prod, det, nx, ny;
  logic [1:0]         psel;
  logic               psub;

  // dividers
  logic [DW-1:0] rem_x, rem_y, dvs;
  logic [17:0]   q_x, q_y;
  logic [53:0]   abs_det, abs_nx, abs_ny;
  logic          ge_x, ge_y;

  // sampling
  logic [8:0]  w_sat, h_sat, wm2, hm2;
  logic [15:0] hi_x, hi_y, sx, sy;
  logic [7:0]  ix, iy;
  logic [8:0]  wx, wy;
  logic [1:0]  tap;
  logic [17:0] wgt;
  logic [33:0] prod2, acc, rnd;
  logic        sing;

  logic in_acc, out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = rst || (state != awbs_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign mem_we    = in_acc && (in_data.cmd == awbs_pkg::CMD_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      a0    <= 26'd65536;
      a1    <= '0;
      a2    <= '0;
      a3    <= 26'd65536;
      tx    <= '0;
      ty    <= '0;
      w_cfg <= 9'd256;
      h_cfg <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        awbs_pkg::REG_A0: a0    <= cfg_data;
        awbs_pkg::REG_A1: a1    <= cfg_data;
        awbs_pkg::REG_A2: a2    <= cfg_data;
        awbs_pkg::REG_A3: a3    <= cfg_data;
        awbs_pkg::REG_TX: tx    <= cfg_data;
        awbs_pkg::REG_TY: ty    <= cfg_data;
        awbs_pkg::REG_W:  w_cfg <= cfg_data[8:0];
        awbs_pkg::REG_H:  h_cfg <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= awbs_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_clr ? 5'd0 : 5'(cnt + 5'd1);
    end
  end

  always_comb begin
    state_next = state;
    cnt_clr    = 1'b1;
    unique case (state)
      awbs_pkg::ST_IDLE: begin
        if (in_acc && in_data.cmd == awbs_pkg::CMD_SAMPLE) state_next = awbs_pkg::ST_MUL;
      end
      awbs_pkg::ST_MUL: begin
        cnt_clr = (cnt == 5'd6);
        if (cnt == 5'd6) state_next = awbs_pkg::ST_DIV;
      end
      awbs_pkg::ST_DIV: begin
        cnt_clr = 1'b0;
        if (cnt == 5'd0 && det == '0) begin
          cnt_clr    = 1'b1;
          state_next = awbs_pkg::ST_HOLD;
        end else if (cnt == 5'd18) begin
          cnt_clr    = 1'b1;
          state_next = awbs_pkg::ST_FETCH;
        end
      end
      awbs_pkg::ST_FETCH: begin
        cnt_clr = (cnt == 5'd5);
        if (cnt == 5'd5) state_next = awbs_pkg::ST_HOLD;
      end
      awbs_pkg::ST_HOLD: begin
        if (out_free) state_next = awbs_pkg::ST_IDLE;
      end
      default: state_next = awbs_pkg::ST_IDLE;
    endcase
  end

  // ---------------- products: det, nx, ny ----------------
  assign dxs = $signed({3'b000, col_r, 16'h0000}) - $signed({tx[25], tx});
  assign dys = $signed({3'b000, row_r, 16'h0000}) - $signed({ty[25], ty});

  always_comb begin
    case (cnt[2:0])
      3'd0:    begin mop_a = $signed({a0[25], a0}); mop_b = $signed({a3[25], a3}); end
      3'd1:    begin mop_a = $signed({a1[25], a1}); mop_b = $signed({a2[25], a2}); end
      3'd2:    begin mop_a = dxs;                   mop_b = $signed({a3[25], a3}); end
      3'd3:    begin mop_a = dys;                   mop_b = $signed({a2[25], a2}); end
      3'd4:    begin mop_a = dys;                   mop_b = $signed({a0[25], a0}); end
      default: begin mop_a = dxs;                   mop_b = $signed({a1[25], a1}); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      col_r <= in_data.col;
      row_r <= in_data.row;
      det   <= '0;
      nx    <= '0;
      ny    <= '0;
    end
    if (state == awbs_pkg::ST_MUL) begin
      prod <= mop_a * mop_b;
      psel <= cnt[2:1];
      psub <= cnt[0];
      if (cnt != 5'd0) begin
        case (psel)
          2'd0:    det <= psub ? det - prod : det + prod;
          2'd1:    nx  <= psub ? nx - prod : nx + prod;
          default: ny  <= psub ? ny - prod : ny + prod;
        endcase
      end
    end
  end

  // ---------------- two restoring divider lanes ----------------
  assign abs_det = det[53] ? 54'(-det) : det;
  assign abs_nx  = nx[53] ? 54'(-nx) : nx;
  assign abs_ny  = ny[53] ? 54'(-ny) : ny;
  assign ge_x    = (rem_x >= dvs);
  assign ge_y    = (rem_y >= dvs);

  always_ff @(posedge clk) begin
    if (state == awbs_pkg::ST_DIV) begin
      if (cnt == 5'd0) begin
        // opposite signs floor to a negative value, which clamps to zero
        rem_x <= (nx[53] == det[53]) ? {10'd0, abs_nx, 8'd0} : '0;
        rem_y <= (ny[53] == det[53]) ? {10'd0, abs_ny, 8'd0} : '0;
        dvs   <= {1'b0, abs_det, 17'd0};
        q_x   <= '0;
        q_y   <= '0;
        sing  <= (det == '0);
      end else begin
        if (ge_x) rem_x <= rem_x - dvs;
        if (ge_y) rem_y <= rem_y - dvs;
        q_x <= {q_x[16:0], ge_x};
        q_y <= {q_y[16:0], ge_y};
        dvs <= dvs >> 1;
      end
    end
  end

  // ---------------- clamp and fetch ----------------
  always_comb begin
    w_sat = (w_cfg < 9'd2) ? 9'd2 : (w_cfg > 9'(awbs_pkg::MAX_WIDTH))
          ? 9'(awbs_pkg::MAX_WIDTH) : w_cfg;
    h_sat = (h_cfg < 9'd2) ? 9'd2 : (h_cfg > 9'(awbs_pkg::MAX_HEIGHT))
          ? 9'(awbs_pkg::MAX_HEIGHT) : h_cfg;
    wm2   = w_sat - 9'd2;
    hm2   = h_sat - 9'd2;
    hi_x  = {wm2[7:0], 8'h00};
    hi_y  = {hm2[7:0], 8'h00};
    // a set top bit means the quotient overran and saturates
    sx    = (q_x[17] || q_x[16:0] > {1'b0, hi_x}) ? hi_x : q_x[15:0];
    sy    = (q_y[17] || q_y[16:0] > {1'b0, hi_y}) ? hi_y : q_y[15:0];
    ix    = sx[15:8];
    iy    = sy[15:8];
    tap   = cnt[1:0];
    wx    = tap[0] ? {1'b0, sx[7:0]} : 9'(9'd256 - {1'b0, sx[7:0]});
    wy    = tap[1] ? {1'b0, sy[7:0]} : 9'(9'd256 - {1'b0, sy[7:0]});
    raddr = mem_we ? {in_data.row, in_data.col}
                   : {8'(iy + {7'd0, tap[1]}), 8'(ix + {7'd0, tap[0]})};
    rnd   = acc + 34'd32768;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[raddr] <= in_data.pixel_in;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (state == awbs_pkg::ST_DIV) acc <= '0;
    if (state == awbs_pkg::ST_FETCH) begin
      if (cnt < 5'd4)                  wgt   <= {9'd0, wx} * {9'd0, wy};
      if (cnt >= 5'd1 && cnt <= 5'd4)  prod2 <= wgt * rdata;
      if (cnt >= 5'd2)                 acc   <= acc + prod2;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == awbs_pkg::ST_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == awbs_pkg::ST_HOLD && out_free) begin
      out_data.singular  <= sing;
      out_data.pixel_out <= sing ? '0 : rnd[31:16];
    end
  end

  // ---------------- checks ----------------
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_data.cmd == awbs_pkg::CMD_SAMPLE) |=> state == awbs_pkg::ST_MUL)
    else $error("sample did not start the multiply sequence");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.singular) |-> out_data.pixel_out == '0)
    else $error("singular word carries a nonzero pixel");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == awbs_pkg::ST_HOLD && out_valid && out_stall) |=> state == awbs_pkg::ST_HOLD)
    else $error("result left hold while the output word was stalled");

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the affine warp bilinear sampler: loads frame-store
// pixels, samples warped points under a range of matrices and image sizes,
// and compares every output word against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  awbs_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  awbs_pkg::out_word_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [2:0]          cfg_index;
  logic [25:0]         cfg_data;

  affine_warp_bilinear_sampler_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [25:0]                     warp_regs [8];
  logic [awbs_pkg::PIXEL_BITS-1:0] frame [awbs_pkg::MAX_WIDTH*awbs_pkg::MAX_HEIGHT];
  bit                              written [awbs_pkg::MAX_WIDTH*awbs_pkg::MAX_HEIGHT];
  awbs_pkg::out_word_t             pending_pixels [$];

  int errors = 0;
  int samples_sent = 0;
  int loads_sent = 0;
  int words_checked = 0;
  int src_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sext26(input logic [25:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint floor_div(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // back-map a destination point to source integer/fraction coordinates
  function automatic void back_map(input logic [7:0] c, input logic [7:0] r,
                                   output bit sing, output int ix, output int iy,
                                   output int fx, output int fy);
    longint a0, a1, a2, a3, t0, t1, det, dx, dy, nx, ny, sx, sy, w, h;
    a0 = sext26(warp_regs[awbs_pkg::REG_A0]);
    a1 = sext26(warp_regs[awbs_pkg::REG_A1]);
    a2 = sext26(warp_regs[awbs_pkg::REG_A2]);
    a3 = sext26(warp_regs[awbs_pkg::REG_A3]);
    t0 = sext26(warp_regs[awbs_pkg::REG_TX]);
    t1 = sext26(warp_regs[awbs_pkg::REG_TY]);
    w = clip(longint'(warp_regs[awbs_pkg::REG_W][8:0]), 2, awbs_pkg::MAX_WIDTH);
    h = clip(longint'(warp_regs[awbs_pkg::REG_H][8:0]), 2, awbs_pkg::MAX_HEIGHT);
    det = a0 * a3 - a1 * a2;
    sing = (det == 0);
    ix = 0; iy = 0; fx = 0; fy = 0;
    if (!sing) begin
      dx = longint'(c) * 65536 - t0;
      dy = longint'(r) * 65536 - t1;
      nx = (dx * a3 - dy * a2) * 256;
      ny = (dy * a0 - dx * a1) * 256;
      sx = clip(floor_div(nx, det), 0, (w - 2) * 256);
      sy = clip(floor_div(ny, det), 0, (h - 2) * 256);
      ix = int'(sx >>> 8);
      iy = int'(sy >>> 8);
      fx = int'(sx & 255);
      fy = int'(sy & 255);
    end
  endfunction

  function automatic awbs_pkg::out_word_t warped_pixel(input awbs_pkg::in_word_t w);
    awbs_pkg::out_word_t o;
    bit sing;
    int ix, iy, fx, fy;
    longint sum;
    back_map(w.col, w.row, sing, ix, iy, fx, fy);
    o.singular = sing;
    o.pixel_out = '0;
    if (!sing) begin
      sum = longint'((256 - fx) * (256 - fy)) * frame[iy*awbs_pkg::MAX_WIDTH + ix]
          + longint'(fx * (256 - fy)) * frame[iy*awbs_pkg::MAX_WIDTH + ix + 1]
          + longint'((256 - fx) * fy) * frame[(iy+1)*awbs_pkg::MAX_WIDTH + ix]
          + longint'(fx * fy) * frame[(iy+1)*awbs_pkg::MAX_WIDTH + ix + 1];
      o.pixel_out = awbs_pkg::PIXEL_BITS'((sum + 32768) >> 16);
    end
    return o;
  endfunction

  // one input word; in_valid is left high so back-to-back words need no toggle
  task automatic send_word(input awbs_pkg::in_word_t w);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (w.cmd == awbs_pkg::CMD_LOAD) begin
      frame[{w.row, w.col}]   = w.pixel_in;
      written[{w.row, w.col}] = 1'b1;
      loads_sent++;
    end else begin
      pending_pixels.push_back(warped_pixel(w));
      samples_sent++;
    end
  endtask

  task automatic load_pixel(input int c, input int r, input logic [15:0] v);
    awbs_pkg::in_word_t w;
    w.cmd = awbs_pkg::CMD_LOAD; w.col = 8'(c); w.row = 8'(r); w.pixel_in = v;
    send_word(w);
  endtask

  // fills any unwritten neighbor first so a sample never reads garbage
  task automatic sample_at(input int c, input int r);
    awbs_pkg::in_word_t w;
    bit sing;
    int ix, iy, fx, fy;
    back_map(8'(c), 8'(r), sing, ix, iy, fx, fy);
    if (!sing) begin
      for (int k = 0; k < 4; k++)
        if (!written[(iy + k/2)*awbs_pkg::MAX_WIDTH + ix + k%2])
          load_pixel(ix + k%2, iy + k/2, 16'($urandom));
    end
    w.cmd = awbs_pkg::CMD_SAMPLE; w.col = 8'(c); w.row = 8'(r);
    w.pixel_in = 16'($urandom);
    send_word(w);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [25:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    warp_regs[idx] = (idx == awbs_pkg::REG_W || idx == awbs_pkg::REG_H) ?
                     {17'd0, val[8:0]} : val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_warp(input int a0, input int a1, input int a2, input int a3,
                          input int tx, input int ty, input int w, input int h);
    drain();
    write_reg(awbs_pkg::REG_A0, 26'(a0));
    write_reg(awbs_pkg::REG_A1, 26'(a1));
    write_reg(awbs_pkg::REG_A2, 26'(a2));
    write_reg(awbs_pkg::REG_A3, 26'(a3));
    write_reg(awbs_pkg::REG_TX, 26'(tx));
    write_reg(awbs_pkg::REG_TY, 26'(ty));
    write_reg(awbs_pkg::REG_W,  26'(w));
    write_reg(awbs_pkg::REG_H,  26'(h));
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("output word with nothing expected: %h", out_data);
        errors++;
      end else begin
        awbs_pkg::out_word_t e;
        e = pending_pixels.pop_front();
        words_checked++;
        if (out_data.pixel_out !== e.pixel_out) begin
          $error("pixel_out expected %h actual %h", e.pixel_out, out_data.pixel_out);
          errors++;
        end
        if (out_data.singular !== e.singular) begin
          $error("singular expected %b actual %b", e.singular, out_data.singular);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_identity;
    load_pixel(0, 0, 16'h0000);
    load_pixel(1, 0, 16'hFFFF);
    load_pixel(0, 1, 16'hFFFF);
    load_pixel(1, 1, 16'h0000);
    load_pixel(255, 255, 16'hFFFF);
    sample_at(0, 0);
    sample_at(255, 255);
    sample_at(254, 254);
    sample_at(255, 0);
    sample_at(0, 255);
  endtask

  task automatic test_half_scale;
    // 2x zoom with fractional shifts gives x fraction 64, y fraction 0 or 128, and half-up rounding
    set_warp(131072, 0, 0, 131072, 32768, -65536, 256, 256);
    sample_at(0, 0);
    sample_at(1, 1);
    sample_at(3, 2);
    sample_at(255, 255);
  endtask

  task automatic test_singular;
    set_warp(0, 0, 0, 0, 0, 0, 256, 256);
    sample_at(7, 9);
    set_warp(65536, 65536, 65536, 65536, 0, 0, 256, 256);
    sample_at(255, 255);
  endtask

  task automatic test_sizes;
    set_warp(65536, 0, 0, 65536, 0, 0, 0, 1);
    sample_at(200, 200);
    set_warp(65536, 0, 0, 65536, 0, 0, 511, 300);
    sample_at(255, 255);
    set_warp(65536, 0, 0, 65536, 0, 0, 2, 256);
    sample_at(128, 128);
  endtask

  task automatic test_extremes;
    set_warp(-33554432, 33554431, -33554432, -33554432,
             33554431, -33554432, 256, 256);
    sample_at(0, 0);
    sample_at(255, 255);
    set_warp(33554431, 0, 0, -65536, -33554432, 33554431, 16, 16);
    sample_at(255, 0);
  endtask

  task automatic random_warp;
    int w, h;
    case ($urandom_range(3))
      0: set_warp(26'($urandom), 26'($urandom), 26'($urandom), 26'($urandom),
                  26'($urandom), 26'($urandom), 9'($urandom), 9'($urandom));
      1: set_warp(65536, 0, 0, 65536, 0, 0, 256, 256);
      default: begin
        w = ($urandom_range(9) == 0) ? 256 : $urandom_range(2, 16);
        h = ($urandom_range(9) == 0) ? 256 : $urandom_range(2, 16);
        set_warp($urandom_range(4096, 262144) * ($urandom_range(1) ? 1 : -1),
                 $urandom_range(65536) - 32768, $urandom_range(65536) - 32768,
                 $urandom_range(4096, 262144),
                 $urandom_range(1048576) - 524288, $urandom_range(1048576) - 524288,
                 w, h);
      end
    endcase
  endtask

  task automatic test_random(input int src_pct, input int rx_pct, input int n);
    src_idle_pct = src_pct;
    rx_idle_pct  = rx_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) random_warp();
      if ($urandom_range(4) == 0)
        load_pixel($urandom_range(255), $urandom_range(255), 16'($urandom));
      else
        sample_at($urandom_range(255), $urandom_range(255));
    end
  endtask

  task automatic test_backpressure;
    src_idle_pct = 0;
    rx_idle_pct  = 0;
    set_warp(60000, 3000, -2000, 70000, 12345, -54321, 12, 10);
    hold_left = 300;
    for (int i = 0; i < 12; i++) sample_at($urandom_range(255), $urandom_range(255));
    // sender waits for every word, then resumes
    drain();
    for (int i = 0; i < 6; i++) sample_at($urandom_range(255), $urandom_range(255));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = awbs_pkg::REG_A0;
    cfg_data = '0;
    warp_regs = '{26'd65536, 26'd0, 26'd0, 26'd65536, 26'd0, 26'd0, 26'd256, 26'd256};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity();
    test_half_scale();
    test_singular();
    test_sizes();
    test_extremes();
    test_random(9, 54, 50);
    test_random(54, 9, 50);
    test_random(0, 0, 50);
    test_backpressure();
    drain();

    $display("Covered %0d loads and %0d samples (%0d words checked) over identity,",
             loads_sent, samples_sent, words_checked);
    $display("zoom, singular, size saturation, extreme and random warps, back-pressure.");
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
